>>> hw/rtl/qpam_pkg.sv
// qpam_pkg: widths, register map, reset values and shared types of the attitude mixer.
// No dependencies; every other RTL file imports this package.
package qpam_pkg;

    // Error history depth (ring entries, each holding both axis errors)
    localparam int HIST_DEPTH = 5;
    localparam int POS_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

    // Configuration bus
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = ADDR_W - 2;

    // Field widths
    localparam int STICK_W = 16;
    localparam int ANGLE_W = 16;
    localparam int ERR_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int LIM_W   = 15;
    localparam int PULSE_W = 12;

    // Scaling constants
    localparam int THROTTLE_BASE_US = 1000;
    localparam int FULL_SCALE_US    = 1000;
    localparam int SETPOINT_SCALE   = 1280;
    localparam int PD_US_PER_MS     = 1000;
    localparam int PD_SHIFT         = 23;

    // Stick quotient unit: quotient never exceeds the scale
    localparam int Q_W       = $clog2(SETPOINT_SCALE + 1);
    localparam int QS_W      = Q_W + 1;
    localparam int NUM_W     = LIM_W + Q_W;
    localparam int DIV_CNT_W = $clog2(Q_W);

    // PD arithmetic
    localparam int PD_PROD_W   = 2 * (GAIN_W + 1);
    localparam int PD_MAG_W    = PD_PROD_W - 1;
    localparam int PD_SCALED_W = PD_MAG_W + $clog2(PD_US_PER_MS);
    localparam int U_W         = PD_SCALED_W - PD_SHIFT + 1;
    localparam int MIX_W       = U_W + 2;

    // Register map
    typedef enum logic [IDX_W-1:0] {
        REG_PROP_GAIN   = 3'd0,
        REG_DIFF_GAIN   = 3'd1,
        REG_STICK_LIMIT = 3'd2,
        REG_PULSE_MIN   = 3'd3,
        REG_PULSE_MAX   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  diff_gain;
        logic [LIM_W-1:0]   stick_limit;
        logic [PULSE_W-1:0] pulse_min;
        logic [PULSE_W-1:0] pulse_max;
    } cfg_t;

    localparam cfg_t CFG_RST = '{
        prop_gain:   16'd655,
        diff_gain:   16'd13107,
        stick_limit: 15'd23170,
        pulse_min:   12'd1000,
        pulse_max:   12'd2000
    };

    // One ring entry holds both axis errors
    typedef struct packed {
        logic signed [ERR_W-1:0] roll_err;
        logic signed [ERR_W-1:0] pitch_err;
    } ring_entry_t;

    typedef struct packed {
        logic             rd_en;
        logic [POS_W-1:0] rd_addr;
        logic             wr_en;
        logic [POS_W-1:0] wr_addr;
        ring_entry_t      wr_data;
    } ring_req_t;

    // Divider control and status
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [LIM_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> hw/rtl/qpam_if.sv
// qpam_if: request and result channel interfaces of the attitude mixer.
// Depends on qpam_pkg for field widths.
interface qpam_cmd_if;
    import qpam_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [STICK_W-1:0] left_stick_x;
    logic signed [STICK_W-1:0] left_stick_y;
    logic signed [STICK_W-1:0] right_stick_x;
    logic signed [STICK_W-1:0] right_stick_y;
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [ANGLE_W-1:0] pitch_angle;

    modport source (
        output valid, left_stick_x, left_stick_y, right_stick_x, right_stick_y,
        output roll_angle, pitch_angle,
        input  ready
    );

    modport sink (
        input  valid, left_stick_x, left_stick_y, right_stick_x, right_stick_y,
        input  roll_angle, pitch_angle,
        output ready
    );
endinterface

interface qpam_motor_if;
    import qpam_pkg::*;

    logic               valid;
    logic               ready;
    logic [PULSE_W-1:0] right_pulse;
    logic [PULSE_W-1:0] left_pulse;
    logic [PULSE_W-1:0] front_pulse;
    logic [PULSE_W-1:0] rear_pulse;

    modport source (
        output valid, right_pulse, left_pulse, front_pulse, rear_pulse,
        input  ready
    );

    modport sink (
        input  valid, right_pulse, left_pulse, front_pulse, rear_pulse,
        output ready
    );
endinterface

>>> hw/rtl/qpam_regs.sv
// qpam_regs: APB-style configuration registers (gains, stick limit, pulse limits).
// Depends on qpam_pkg.
module qpam_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [qpam_pkg::ADDR_W-1:0]  paddr,
    input  logic [qpam_pkg::DATA_W-1:0]  pwdata,
    output logic [qpam_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output qpam_pkg::cfg_t               cfg
);
    import qpam_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // Write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_PROP_GAIN:   cfg_next.prop_gain   = pwdata[GAIN_W-1:0];
                REG_DIFF_GAIN:   cfg_next.diff_gain   = pwdata[GAIN_W-1:0];
                REG_STICK_LIMIT: cfg_next.stick_limit = pwdata[LIM_W-1:0];
                REG_PULSE_MIN:   cfg_next.pulse_min   = pwdata[PULSE_W-1:0];
                REG_PULSE_MAX:   cfg_next.pulse_max   = pwdata[PULSE_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // Read decode
    always_comb
    begin
        unique case (idx)
            REG_PROP_GAIN:   prdata = DATA_W'(cfg_reg.prop_gain);
            REG_DIFF_GAIN:   prdata = DATA_W'(cfg_reg.diff_gain);
            REG_STICK_LIMIT: prdata = DATA_W'(cfg_reg.stick_limit);
            REG_PULSE_MIN:   prdata = DATA_W'(cfg_reg.pulse_min);
            REG_PULSE_MAX:   prdata = DATA_W'(cfg_reg.pulse_max);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hw/rtl/qpam_ring.sv
// qpam_ring: error history memory, one entry per tick holding roll and pitch errors.
// Depends on qpam_pkg. Synchronous read, data registered from the read address; unwritten entries read as zero.
module qpam_ring (
    input  logic                  clk,
    input  logic                  rst_n,
    input  qpam_pkg::ring_req_t   req,
    output qpam_pkg::ring_entry_t old
);
    import qpam_pkg::*;

    ring_entry_t           ring_mem [HIST_DEPTH];
    ring_entry_t           rd_data_reg;
    logic                  rd_vld_reg;
    logic [HIST_DEPTH-1:0] vld_reg;

    // Storage array: the write of a tick always follows its own read, so no bypass
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            ring_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= ring_mem[req.rd_addr];
        end
    end

    // Per-entry written flags stand in for the all-zero reset contents
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= vld_reg[req.rd_addr];
            end
        end
    end

    assign old = rd_vld_reg ? rd_data_reg : '0;

endmodule

>>> hw/rtl/qpam_div.sv
// qpam_div: restoring divider, one quotient bit per cycle, for the stick scaling.
// Depends on qpam_pkg. Dividend must be below divisor * 2**Q_W.
module qpam_div (
    input  logic               clk,
    input  logic               rst_n,
    input  qpam_pkg::div_req_t req,
    output qpam_pkg::div_rsp_t rsp
);
    import qpam_pkg::*;

    logic [LIM_W-1:0]     rem_reg;
    logic [LIM_W-1:0]     rem_next;
    logic [Q_W-1:0]       sh_reg;
    logic [Q_W-1:0]       sh_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [LIM_W:0]       trial;
    logic                 fits;

    // Shift in next dividend bit, subtract when it fits; quotient bits fill sh_reg
    always_comb
    begin
        trial     = {rem_reg, sh_reg[Q_W-1]};
        fits      = (trial >= {1'b0, req.divisor});
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = req.dividend[NUM_W-1:Q_W];
            sh_next   = req.dividend[Q_W-1:0];
            cnt_next  = DIV_CNT_W'(Q_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? LIM_W'(trial - {1'b0, req.divisor}) : trial[LIM_W-1:0];
            sh_next  = {sh_reg[Q_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = sh_reg;

endmodule

>>> hw/rtl/quad_plus_pd_attitude_mixer_top.sv
// quad_plus_pd_attitude_mixer_top: plus-frame quadcopter mixer with PD attitude hold.
// Depends on qpam_pkg, qpam_if, qpam_regs, qpam_ring, qpam_div.
//
//   port    | dir | handshake     | carries
//   --------+-----+---------------+------------------------------------------
//   cmd     | in  | valid/ready   | four sticks, roll and pitch angle
//   motor   | out | valid/ready   | right, left, front, rear pulse (us)
//   APB     | in  | psel/penable  | gains, stick limit, pulse limits
//
// One request at a time: from acceptance to a loaded result, the shared 11-step divider
// runs four times (one per stick quotient), followed by the PD and mix states.
// The next request is taken the cycle after the result register loads, while that
// result may still wait for motor.ready; a full result register stalls the mix step.
// Reset: error history reads as zero until written (per-entry flags), no clear pass.
module quad_plus_pd_attitude_mixer_top (
    input  logic                         clk,
    input  logic                         rst_n,
    qpam_cmd_if.sink                     cmd,
    qpam_motor_if.source                 motor,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [qpam_pkg::ADDR_W-1:0]  paddr,
    input  logic [qpam_pkg::DATA_W-1:0]  pwdata,
    output logic [qpam_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import qpam_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DNUM,
        S_DSTART,
        S_DWAIT,
        S_ERR,
        S_PMUL,
        S_DMUL,
        S_SUM,
        S_ABS,
        S_SCALE,
        S_MIX
    } state_t;

    typedef struct packed {
        logic             neg;
        logic [LIM_W-1:0] mag;
    } stick_t;

    // Clamp a stick to +/- lim, split into sign and magnitude
    function automatic stick_t clamp_stick(input logic signed [STICK_W-1:0] s,
                                           input logic [LIM_W-1:0] lim);
        logic signed [STICK_W:0] s_x;
        logic signed [STICK_W:0] lim_x;
        logic signed [STICK_W:0] neg_s;
        stick_t                  r;
        s_x   = {s[STICK_W-1], s};
        lim_x = $signed({2'b00, lim});
        neg_s = -s_x;
        r.neg = s[STICK_W-1];
        if (s_x > lim_x)
        begin
            r.mag = lim;
        end
        else if (s_x < -lim_x)
        begin
            r.mag = lim;
        end
        else if (s[STICK_W-1])
        begin
            r.mag = neg_s[LIM_W-1:0];
        end
        else
        begin
            r.mag = s_x[LIM_W-1:0];
        end
        return r;
    endfunction

    // Saturate a 17-bit error to 16 bits
    function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [ERR_W:0] v);
        logic signed [ERR_W-1:0] r;
        if (v[ERR_W] != v[ERR_W-1])
        begin
            r = v[ERR_W] ? {1'b1, {(ERR_W-1){1'b0}}} : {1'b0, {(ERR_W-1){1'b1}}};
        end
        else
        begin
            r = v[ERR_W-1:0];
        end
        return r;
    endfunction

    // Upper limit first, then lower
    function automatic logic [PULSE_W-1:0] limit_pulse(input logic signed [MIX_W-1:0] p,
                                                       input logic [PULSE_W-1:0] lo,
                                                       input logic [PULSE_W-1:0] hi);
        logic signed [MIX_W-1:0] lo_x;
        logic signed [MIX_W-1:0] hi_x;
        logic signed [MIX_W-1:0] r;
        lo_x = $signed({{(MIX_W-PULSE_W){1'b0}}, lo});
        hi_x = $signed({{(MIX_W-PULSE_W){1'b0}}, hi});
        r    = p;
        if (r > hi_x)
        begin
            r = hi_x;
        end
        if (r < lo_x)
        begin
            r = lo_x;
        end
        return r[PULSE_W-1:0];
    endfunction

    function automatic logic signed [MIX_W-1:0] ext_q(input logic signed [QS_W-1:0] v);
        return {{(MIX_W-QS_W){v[QS_W-1]}}, v};
    endfunction

    function automatic logic signed [MIX_W-1:0] ext_u(input logic signed [U_W-1:0] v);
        return {{(MIX_W-U_W){v[U_W-1]}}, v};
    endfunction

    cfg_t        cfg;
    ring_req_t   ring_req;
    ring_entry_t ring_old;
    div_req_t    div_req;
    div_rsp_t    div_rsp;

    // Control and registered outputs
    state_t             state_reg;
    state_t             state_next;
    logic [1:0]         k_reg;
    logic [1:0]         k_next;
    logic               ax_reg;
    logic               ax_next;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [PULSE_W-1:0] pulse_reg  [4];
    logic [PULSE_W-1:0] pulse_next [4];

    // Working registers
    stick_t                      stick_reg  [4];
    stick_t                      stick_next [4];
    logic signed [ANGLE_W-1:0]   roll_reg;
    logic signed [ANGLE_W-1:0]   roll_next;
    logic signed [ANGLE_W-1:0]   pitch_reg;
    logic signed [ANGLE_W-1:0]   pitch_next;
    logic [NUM_W-1:0]            num_reg;
    logic [NUM_W-1:0]            num_next;
    logic signed [QS_W-1:0]      qs_reg  [4];
    logic signed [QS_W-1:0]      qs_next [4];
    logic signed [ERR_W-1:0]     err_reg  [2];
    logic signed [ERR_W-1:0]     err_next [2];
    logic signed [ERR_W:0]       diff_reg  [2];
    logic signed [ERR_W:0]       diff_next [2];
    logic signed [PD_PROD_W-1:0] prod_reg;
    logic signed [PD_PROD_W-1:0] prod_next;
    logic signed [PD_PROD_W-1:0] acc_reg;
    logic signed [PD_PROD_W-1:0] acc_next;
    logic [PD_MAG_W-1:0]         mag_reg;
    logic [PD_MAG_W-1:0]         mag_next;
    logic                        neg_reg;
    logic                        neg_next;
    logic signed [U_W-1:0]       u_reg  [2];
    logic signed [U_W-1:0]       u_next [2];

    // Combinational helpers
    logic                        cmd_acc;
    logic                        out_free;
    logic [LIM_W-1:0]            lim_eff;
    logic [Q_W-1:0]              scale_k;
    logic signed [QS_W-1:0]      q_ext;
    logic signed [ERR_W:0]       roll_raw;
    logic signed [ERR_W:0]       pitch_raw;
    logic signed [ERR_W-1:0]     roll_err;
    logic signed [ERR_W-1:0]     pitch_err;
    logic signed [GAIN_W:0]      mul_a;
    logic signed [GAIN_W:0]      mul_b;
    logic signed [PD_PROD_W-1:0] mul_p;
    logic signed [PD_PROD_W-1:0] acc_abs;
    logic [PD_SCALED_W-1:0]      pd_scaled;
    logic signed [U_W-1:0]       pd_q;
    logic signed [MIX_W-1:0]     thr;
    logic signed [MIX_W-1:0]     yaw;
    logic signed [MIX_W-1:0]     u_roll;
    logic signed [MIX_W-1:0]     u_pitch;

    qpam_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    qpam_ring u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ring_req),
        .old   (ring_old)
    );

    qpam_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Handshakes
    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_acc   = cmd.valid && cmd.ready;
    assign out_free  = !out_valid_reg || motor.ready;

    assign motor.valid       = out_valid_reg;
    assign motor.right_pulse = pulse_reg[0];
    assign motor.left_pulse  = pulse_reg[1];
    assign motor.front_pulse = pulse_reg[2];
    assign motor.rear_pulse  = pulse_reg[3];

    // A zero stick limit behaves as one
    assign lim_eff = (cfg.stick_limit == '0) ? LIM_W'(1) : cfg.stick_limit;

    // Ring access: read old errors on accept, write new errors in S_ERR
    assign ring_req.rd_en   = cmd_acc;
    assign ring_req.rd_addr = pos_reg;
    assign ring_req.wr_en   = (state_reg == S_ERR);
    assign ring_req.wr_addr = pos_reg;
    assign ring_req.wr_data = '{roll_err: roll_err, pitch_err: pitch_err};

    assign div_req.start    = (state_reg == S_DSTART);
    assign div_req.dividend = num_reg;
    assign div_req.divisor  = lim_eff;

    // Quotient order: throttle, yaw, roll set-point, pitch set-point
    assign scale_k = (k_reg[1] == 1'b0) ? Q_W'(FULL_SCALE_US) : Q_W'(SETPOINT_SCALE);
    assign q_ext   = $signed({1'b0, div_rsp.quotient});

    // Axis errors against the set-points
    assign roll_raw  = $signed({{(ERR_W+1-QS_W){qs_reg[2][QS_W-1]}}, qs_reg[2]})
                     - $signed({roll_reg[ANGLE_W-1], roll_reg});
    assign pitch_raw = $signed({{(ERR_W+1-QS_W){qs_reg[3][QS_W-1]}}, qs_reg[3]})
                     - $signed({pitch_reg[ANGLE_W-1], pitch_reg});
    assign roll_err  = sat_err(roll_raw);
    assign pitch_err = sat_err(pitch_raw);

    // Shared PD multiplier: gain times error, then gain times difference
    assign mul_a = (state_reg == S_PMUL) ? $signed({1'b0, cfg.prop_gain})
                                         : $signed({1'b0, cfg.diff_gain});
    assign mul_b = (state_reg == S_PMUL) ? $signed({err_reg[ax_reg][ERR_W-1], err_reg[ax_reg]})
                                         : diff_reg[ax_reg];
    assign mul_p = mul_a * mul_b;

    assign acc_abs   = acc_reg[PD_PROD_W-1] ? -acc_reg : acc_reg;
    assign pd_scaled = ({{(PD_SCALED_W-PD_MAG_W){1'b0}}, mag_reg} * PD_SCALED_W'(PD_US_PER_MS))
                     + (PD_SCALED_W'(1) << (PD_SHIFT - 1));
    assign pd_q      = $signed({1'b0, pd_scaled[PD_SCALED_W-1:PD_SHIFT]});

    // Mixer terms
    assign thr     = MIX_W'(THROTTLE_BASE_US) - ext_q(qs_reg[0]);
    assign yaw     = ext_q(qs_reg[1]);
    assign u_roll  = ext_u(u_reg[0]);
    assign u_pitch = ext_u(u_reg[1]);

    // Sequencer next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        ax_next        = ax_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        pulse_next     = pulse_reg;
        stick_next     = stick_reg;
        roll_next      = roll_reg;
        pitch_next     = pitch_reg;
        num_next       = num_reg;
        qs_next        = qs_reg;
        err_next       = err_reg;
        diff_next      = diff_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        u_next         = u_reg;

        if (out_valid_reg && motor.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc)
                begin
                    stick_next[0] = clamp_stick(cmd.right_stick_y, lim_eff);
                    stick_next[1] = clamp_stick(cmd.right_stick_x, lim_eff);
                    stick_next[2] = clamp_stick(cmd.left_stick_x, lim_eff);
                    stick_next[3] = clamp_stick(cmd.left_stick_y, lim_eff);
                    roll_next     = cmd.roll_angle;
                    pitch_next    = cmd.pitch_angle;
                    k_next        = 2'd0;
                    state_next    = S_DNUM;
                end
            end
            S_DNUM:
            begin
                // magnitude * scale + lim/2, rounded quotient follows
                num_next   = ({{Q_W{1'b0}}, stick_reg[k_reg].mag} * {{LIM_W{1'b0}}, scale_k})
                           + NUM_W'(lim_eff >> 1);
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (div_rsp.done)
                begin
                    qs_next[k_reg] = stick_reg[k_reg].neg ? -q_ext : q_ext;
                    if (k_reg == 2'd3)
                    begin
                        state_next = S_ERR;
                    end
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = S_DNUM;
                    end
                end
            end
            S_ERR:
            begin
                err_next[0]  = roll_err;
                err_next[1]  = pitch_err;
                diff_next[0] = $signed({roll_err[ERR_W-1], roll_err})
                             - $signed({ring_old.roll_err[ERR_W-1], ring_old.roll_err});
                diff_next[1] = $signed({pitch_err[ERR_W-1], pitch_err})
                             - $signed({ring_old.pitch_err[ERR_W-1], ring_old.pitch_err});
                pos_next     = (pos_reg == POS_W'(HIST_DEPTH - 1)) ? '0 : pos_reg + 1'b1;
                ax_next      = 1'b0;
                state_next   = S_PMUL;
            end
            S_PMUL:
            begin
                prod_next  = mul_p;
                state_next = S_DMUL;
            end
            S_DMUL:
            begin
                acc_next   = prod_reg;
                prod_next  = mul_p;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                acc_next   = acc_reg + prod_reg;
                state_next = S_ABS;
            end
            S_ABS:
            begin
                neg_next   = acc_reg[PD_PROD_W-1];
                mag_next   = acc_abs[PD_MAG_W-1:0];
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                u_next[ax_reg] = neg_reg ? -pd_q : pd_q;
                ax_next        = ~ax_reg;
                state_next     = ax_reg ? S_MIX : S_PMUL;
            end
            S_MIX:
            begin
                // hold here while the previous result is still waiting
                if (out_free)
                begin
                    pulse_next[0]  = limit_pulse(thr - u_roll + yaw, cfg.pulse_min,
                                                 cfg.pulse_max);
                    pulse_next[1]  = limit_pulse(thr + u_roll + yaw, cfg.pulse_min,
                                                 cfg.pulse_max);
                    pulse_next[2]  = limit_pulse(thr + u_pitch - yaw, cfg.pulse_min,
                                                 cfg.pulse_max);
                    pulse_next[3]  = limit_pulse(thr - u_pitch - yaw, cfg.pulse_min,
                                                 cfg.pulse_max);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= 2'd0;
            ax_reg        <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            pulse_reg     <= '{default: '0};
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            ax_reg        <= ax_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            pulse_reg     <= pulse_next;
        end
    end

    // Datapath working registers
    always_ff @(posedge clk)
    begin
        stick_reg <= stick_next;
        roll_reg  <= roll_next;
        pitch_reg <= pitch_next;
        num_reg   <= num_next;
        qs_reg    <= qs_next;
        err_reg   <= err_next;
        diff_reg  <= diff_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        u_reg     <= u_next;
    end

endmodule

>>> hw/rtl/qpam_checker.sv
// qpam_checker: port-level assertions for the attitude mixer, bound to the top level.
// Depends on qpam_pkg and quad_plus_pd_attitude_mixer_top.
module qpam_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_ready,
    input logic                          motor_valid,
    input logic                          motor_ready,
    input logic [qpam_pkg::PULSE_W-1:0]  right_pulse,
    input logic [qpam_pkg::PULSE_W-1:0]  left_pulse,
    input logic [qpam_pkg::PULSE_W-1:0]  front_pulse,
    input logic [qpam_pkg::PULSE_W-1:0]  rear_pulse
);
    import qpam_pkg::*;

    // Result register is empty during reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !motor_valid)
        else $error("result valid during reset");

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        motor_valid && !motor_ready |=> motor_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its pulses
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        motor_valid && !motor_ready |=>
            $stable(right_pulse) && $stable(left_pulse) &&
            $stable(front_pulse) && $stable(rear_pulse))
        else $error("result changed while stalled");

    // One request in flight: accepting a request closes the command side
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("second request taken while busy");

    // A new result only appears at the end of a computation
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(motor_valid) |-> $past(!cmd_ready))
        else $error("result loaded without a request in work");

endmodule

bind quad_plus_pd_attitude_mixer_top qpam_checker u_qpam_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .motor_valid (motor.valid),
    .motor_ready (motor.ready),
    .right_pulse (motor.right_pulse),
    .left_pulse  (motor.left_pulse),
    .front_pulse (motor.front_pulse),
    .rear_pulse  (motor.rear_pulse)
);

>>> tb/testbench.sv
// testbench: request/result check of the plus-frame PD attitude mixer with its own mixer model.
// Depends on qpam_pkg, qpam_if and quad_plus_pd_attitude_mixer_top; drives the APB port
// between phases and compares every motor result with the oldest predicted pulse set.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import qpam_pkg::*;

    typedef struct packed {
        logic signed [STICK_W-1:0] left_stick_x;
        logic signed [STICK_W-1:0] left_stick_y;
        logic signed [STICK_W-1:0] right_stick_x;
        logic signed [STICK_W-1:0] right_stick_y;
        logic signed [ANGLE_W-1:0] roll_angle;
        logic signed [ANGLE_W-1:0] pitch_angle;
    } stick_cmd_t;

    typedef struct packed {
        logic [PULSE_W-1:0] right_us;
        logic [PULSE_W-1:0] left_us;
        logic [PULSE_W-1:0] front_us;
        logic [PULSE_W-1:0] rear_us;
    } pulse_set_t;

    localparam int ITEMS_PER_SETTING = 158;
    localparam int HOLD_CYCLES       = 400;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    qpam_cmd_if   cmd_bus ();
    qpam_motor_if motor_bus ();

    quad_plus_pd_attitude_mixer_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_bus.sink),
        .motor   (motor_bus.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // Mixer model: configuration copy and error history
    int prop_gain_m   = 655;
    int diff_gain_m   = 13107;
    int stick_limit_m = 23170;
    int pulse_min_m   = 1000;
    int pulse_max_m   = 2000;
    int roll_hist [HIST_DEPTH] = '{default: 0};
    int pitch_hist[HIST_DEPTH] = '{default: 0};
    int hist_pos      = 0;

    stick_cmd_t pending_cmds[$];
    pulse_set_t expected_pulses[$];

    int  fail_count    = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_motor    = 1'b0;
    bit  pressure_go   = 1'b0;
    logic cmd_taken;

    function automatic int clamp_sym(int v, int lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // round(s * scale / lim), halves away from zero
    function automatic int round_scaled(int s, int scale, int lim);
        int mag;
        int q;
        mag = (s < 0) ? -s : s;
        q = (mag * scale + lim / 2) / lim;
        return (s < 0) ? -q : q;
    endfunction

    function automatic int sat_err(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // PD correction in microseconds
    function automatic longint pd_us(int err, int old);
        longint num;
        longint mag;
        longint q;
        num = longint'(prop_gain_m) * err + longint'(diff_gain_m) * (err - old);
        mag = (num < 0) ? -num : num;
        q = (mag * 1000 + (longint'(1) << 22)) >>> 23;
        return (num < 0) ? -q : q;
    endfunction

    // upper limit first, then lower
    function automatic logic [PULSE_W-1:0] clip_pulse(longint p);
        if (p > pulse_max_m) p = pulse_max_m;
        if (p < pulse_min_m) p = pulse_min_m;
        return PULSE_W'(p);
    endfunction

    function automatic pulse_set_t mix_tick(stick_cmd_t c);
        int         lim;
        int         roll_err;
        int         pitch_err;
        longint     thr;
        longint     yaw;
        longint     u_roll;
        longint     u_pitch;
        pulse_set_t r;
        lim = (stick_limit_m == 0) ? 1 : stick_limit_m;
        thr = 1000 - round_scaled(clamp_sym(int'(c.right_stick_y), lim), 1000, lim);
        yaw = round_scaled(clamp_sym(int'(c.right_stick_x), lim), 1000, lim);
        roll_err = sat_err(round_scaled(clamp_sym(int'(c.left_stick_x), lim), 1280, lim)
                           - int'(c.roll_angle));
        pitch_err = sat_err(round_scaled(clamp_sym(int'(c.left_stick_y), lim), 1280, lim)
                            - int'(c.pitch_angle));
        u_roll  = pd_us(roll_err, roll_hist[hist_pos]);
        u_pitch = pd_us(pitch_err, pitch_hist[hist_pos]);
        roll_hist[hist_pos]  = roll_err;
        pitch_hist[hist_pos] = pitch_err;
        hist_pos = (hist_pos + 1 >= HIST_DEPTH) ? 0 : hist_pos + 1;
        r.right_us = clip_pulse(thr - u_roll + yaw);
        r.left_us  = clip_pulse(thr + u_roll + yaw);
        r.front_us = clip_pulse(thr + u_pitch - yaw);
        r.rear_us  = clip_pulse(thr - u_pitch - yaw);
        return r;
    endfunction

    task automatic report_error(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_pulse(string name, logic [PULSE_W-1:0] got, logic [PULSE_W-1:0] want);
        if (got !== want)
            report_error($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Request side: predict on acceptance, remember the handshake for the driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_taken <= 1'b0;
        end
        else
        begin
            cmd_taken <= cmd_bus.valid && cmd_bus.ready;
            if (cmd_bus.valid && cmd_bus.ready)
                expected_pulses.push_back(mix_tick({cmd_bus.left_stick_x, cmd_bus.left_stick_y,
                                                    cmd_bus.right_stick_x, cmd_bus.right_stick_y,
                                                    cmd_bus.roll_angle, cmd_bus.pitch_angle}));
        end
    end

    // Request driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            cmd_bus.valid <= 1'b0;
        end
        else if (!cmd_bus.valid || cmd_taken)
        begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                stick_cmd_t c;
                c = pending_cmds.pop_front();
                cmd_bus.left_stick_x  <= c.left_stick_x;
                cmd_bus.left_stick_y  <= c.left_stick_y;
                cmd_bus.right_stick_x <= c.right_stick_x;
                cmd_bus.right_stick_y <= c.right_stick_y;
                cmd_bus.roll_angle    <= c.roll_angle;
                cmd_bus.pitch_angle   <= c.pitch_angle;
                cmd_bus.valid         <= 1'b1;
            end
            else
            begin
                cmd_bus.valid <= 1'b0;
            end
        end
    end

    // Result side backpressure
    always @(negedge clk)
    begin
        if (!rst_n)
            motor_bus.ready <= 1'b0;
        else
            motor_bus.ready <= !hold_motor && ($urandom_range(99) >= recv_idle_pct);
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && motor_bus.valid && motor_bus.ready)
        begin
            if (expected_pulses.size() == 0)
            begin
                report_error("motor result with no request outstanding");
            end
            else
            begin
                pulse_set_t want;
                want = expected_pulses.pop_front();
                check_pulse("right_pulse", motor_bus.right_pulse, want.right_us);
                check_pulse("left_pulse", motor_bus.left_pulse, want.left_us);
                check_pulse("front_pulse", motor_bus.front_pulse, want.front_us);
                check_pulse("rear_pulse", motor_bus.rear_pulse, want.rear_us);
            end
        end
    end

    // Long receiver stall while the request queue is full
    initial
    begin
        wait (pressure_go);
        @(negedge clk);
        hold_motor <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_motor <= 1'b0;
    end

    task automatic apb_write(reg_idx_t idx, logic [DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PROP_GAIN:   prop_gain_m   = int'(value[GAIN_W-1:0]);
            REG_DIFF_GAIN:   diff_gain_m   = int'(value[GAIN_W-1:0]);
            REG_STICK_LIMIT: stick_limit_m = int'(value[LIM_W-1:0]);
            REG_PULSE_MIN:   pulse_min_m   = int'(value[PULSE_W-1:0]);
            REG_PULSE_MAX:   pulse_max_m   = int'(value[PULSE_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (pending_cmds.size() != 0 || cmd_bus.valid || expected_pulses.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic push_cmd(int lx, int ly, int rx, int ry, int roll, int pitch);
        stick_cmd_t c;
        c.left_stick_x  = STICK_W'(lx);
        c.left_stick_y  = STICK_W'(ly);
        c.right_stick_x = STICK_W'(rx);
        c.right_stick_y = STICK_W'(ry);
        c.roll_angle    = ANGLE_W'(roll);
        c.pitch_angle   = ANGLE_W'(pitch);
        pending_cmds.push_back(c);
    endtask

    function automatic int rand_stick(int lim);
        case ($urandom_range(9))
            0: return int'($urandom_range(65535)) - 32768;
            1: return $urandom_range(1) ? lim : -lim;
            2: return $urandom_range(1) ? 32767 : -32768;
            3: return $urandom_range(1) ? lim + 1 : -lim - 1;
            default: return int'($urandom_range(2 * lim)) - lim;
        endcase
    endfunction

    function automatic int rand_angle();
        case ($urandom_range(9))
            0: return int'($urandom_range(65535)) - 32768;
            1: return $urandom_range(1) ? 23040 : -23040;
            2: return $urandom_range(1) ? 32767 : -32768;
            default: return int'($urandom_range(46080)) - 23040;
        endcase
    endfunction

    // New register setting once idle, then a batch of random ticks
    task automatic run_setting(int pg, int dg, int lim, int pmin, int pmax,
                               int send_pct, int recv_pct, int n);
        wait_drained();
        apb_write(REG_PROP_GAIN, DATA_W'(pg));
        apb_write(REG_DIFF_GAIN, DATA_W'(dg));
        apb_write(REG_STICK_LIMIT, DATA_W'(lim));
        apb_write(REG_PULSE_MIN, DATA_W'(pmin));
        apb_write(REG_PULSE_MAX, DATA_W'(pmax));
        @(posedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (n)
            push_cmd(rand_stick(lim), rand_stick(lim), rand_stick(lim), rand_stick(lim),
                     rand_angle(), rand_angle());
    endtask

    initial
    begin
        cmd_bus.valid         = 1'b0;
        cmd_bus.left_stick_x  = '0;
        cmd_bus.left_stick_y  = '0;
        cmd_bus.right_stick_x = '0;
        cmd_bus.right_stick_y = '0;
        cmd_bus.roll_angle    = '0;
        cmd_bus.pitch_angle   = '0;
        motor_bus.ready       = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        rst_n   = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks under reset settings
        send_idle_pct = 37;
        recv_idle_pct = 56;
        push_cmd(0, 0, 0, 0, 0, 0);
        push_cmd(0, 0, 0, -32768, 0, 0);            // full throttle, clamped
        push_cmd(0, 0, 0, 32767, 0, 0);             // throttle below pulse_min
        push_cmd(0, 0, 32767, 0, 0, 0);
        push_cmd(0, 0, -32768, 0, 0, 0);
        push_cmd(23170, -23170, 23171, -23171, 0, 0);
        push_cmd(32767, 0, 0, 0, -32768, 0);        // roll error saturates high
        push_cmd(-32768, 0, 0, 0, 32767, 0);        // roll error saturates low
        push_cmd(0, 32767, 0, 0, 0, -32768);        // pitch error saturates high
        push_cmd(0, -32768, 0, 0, 0, 32767);        // pitch error saturates low
        push_cmd(0, 0, 0, 0, 23040, -23040);
        push_cmd(0, 0, 0, 0, -23040, 23040);
        push_cmd(-1, 1, -1, 1, -1, 1);
        // constant error for more than one ring turn
        repeat (7)
            push_cmd(11585, -11585, 0, 0, 256, -256);
        push_cmd(0, 0, 0, 0, 0, 0);

        run_setting(65535, 65535, 1, 0, 4095, 37, 56, ITEMS_PER_SETTING);
        run_setting($urandom_range(65535), $urandom_range(65535), $urandom_range(32767, 1),
                    1000, 2000, 37, 56, ITEMS_PER_SETTING);
        run_setting(0, 0, 32767, 0, 4095, 56, 37, ITEMS_PER_SETTING);
        // zero stick limit and crossed pulse limits
        run_setting($urandom_range(65535), $urandom_range(65535), 0, 3000, 500,
                    56, 37, ITEMS_PER_SETTING);
        run_setting(655, 13107, 23170, 1000, 2000, 0, 0, ITEMS_PER_SETTING);
        pressure_go = 1'b1;
        run_setting($urandom_range(65535), 65535, 2000, 1100, 1900, 0, 0, ITEMS_PER_SETTING);

        wait_drained();
        repeat (100) @(negedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

>>> quad_plus_pd_attitude_mixer_top.f
hw/rtl/qpam_pkg.sv
hw/rtl/qpam_if.sv
hw/rtl/qpam_regs.sv
hw/rtl/qpam_ring.sv
hw/rtl/qpam_div.sv
hw/rtl/quad_plus_pd_attitude_mixer_top.sv
hw/rtl/qpam_checker.sv
tb/testbench.sv
